// ===== rtl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg : shared types and constants of the palette colour classifier
// Channel widths, palette geometry and the integer square root step.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

    localparam int CH_W            = 8;   // one colour channel
    localparam int PIX_W           = 3 * CH_W;
    localparam int IDX_W           = 3;   // palette index
    localparam int PALETTE_SLOTS   = 8;   // palette registers present
    localparam int NUM_COLORS_DEF  = 8;   // entries taking part in the search
    localparam int CFG_IDX_W       = 4;   // configuration register index
    localparam int SQ_W            = 2 * CH_W;
    localparam int SUM_W           = SQ_W + 2;  // sum of three squares
    localparam int ROOT_W          = SUM_W / 2;
    localparam int REM_W           = ROOT_W + 1;
    localparam int SQRT_STAGES     = 3;
    localparam int SQRT_STEPS      = ROOT_W / SQRT_STAGES;
    localparam int DIST_STAGES     = 3;   // difference, square, sum
    localparam int SEL_STAGES      = 2;   // arg-min, output select
    localparam int LATENCY         = DIST_STAGES + SQRT_STAGES + SEL_STAGES;

    // Starting minimum, above the largest reachable distance of 441
    localparam logic [ROOT_W-1:0] DIST_START = ROOT_W'(444);

    // Blue in the low byte, red in the high byte
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    typedef color_t palette_t [PALETTE_SLOTS];

    // Running state of the digit-by-digit square root
    typedef struct packed {
        logic [SUM_W-1:0]  rad;   // radicand bits still to bring down
        logic [REM_W-1:0]  rem;   // partial remainder
        logic [ROOT_W-1:0] root;  // root bits so far
    } sqrt_st_t;

    // One result bit: bring down two radicand bits, trial subtract 4q+1
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t st);
        sqrt_st_t          nx;
        logic [REM_W+1:0]  rem2;
        logic [REM_W+1:0]  trial;
        rem2  = {st.rem, st.rad[SUM_W-1 -: 2]};
        trial = {1'b0, st.root, 2'b01};
        nx.rad = {st.rad[SUM_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            nx.rem  = REM_W'(rem2 - trial);
            nx.root = {st.root[ROOT_W-2:0], 1'b1};
        end
        else begin
            nx.rem  = REM_W'(rem2);
            nx.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nearest_palette_color_classifier.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_classifier : maps a BGR pixel to its nearest palette
// colour by floored Euclidean distance; background pixels pass unchanged.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tdata = blue, green, red (8 bits each)
//  m_axis    out        tdata = blue, green, red; tuser = class index
//  cfg       in         cfg_index selects palette entry, cfg_data its colour
//
//  One pixel per cycle while the output is not stalled; the pipeline has
//  3 distance stages, 3 square root stages and 2 select stages.
//  The whole pipeline advances together: it holds only while the output
//  register is full and m_axis_tready is low, and s_axis_tready is low then.
//  rst_n clears the palette to zero and empties the pipeline.
//  cfg_ready is always high; writes to indexes beyond the palette are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_classifier #(
    parameter int NUM_COLORS = npc_pkg::NUM_COLORS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [npc_pkg::PIX_W-1:0]         s_axis_tdata,  // blue, green, red
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [npc_pkg::PIX_W-1:0]         m_axis_tdata,  // blue, green, red
    output logic [npc_pkg::IDX_W-1:0]         m_axis_tuser,  // class_index
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [npc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [npc_pkg::PIX_W-1:0]         cfg_data
);
    import npc_pkg::*;

    localparam int PIX_DLY = DIST_STAGES + SQRT_STAGES;

    palette_t                          palette_reg;
    logic [LATENCY-1:0]                valid_reg;
    color_t                            pix_reg [PIX_DLY];
    logic                              adv;
    logic [NUM_COLORS-1:0][SUM_W-1:0]  sum_sq;
    logic [NUM_COLORS-1:0][ROOT_W-1:0] lane_dist;
    color_t                            out_color;

    // Pipeline moves whenever the output register can be emptied or refilled
    assign adv           = !valid_reg[LATENCY-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;

    // Palette registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PALETTE_SLOTS; k++)
            begin
                palette_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_index < CFG_IDX_W'(PALETTE_SLOTS))
        begin
            palette_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
        end
    end

    // Valid bits travelling with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], s_axis_tvalid};
        end
    end

    // Pixel delay line up to the select stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix_reg[0] <= s_axis_tdata;
            for (int s = 1; s < PIX_DLY; s++)
            begin
                pix_reg[s] <= pix_reg[s-1];
            end
        end
    end

    npc_dist #(.NUM_COLORS(NUM_COLORS)) u_dist (
        .clk     (clk),
        .en      (adv),
        .pixel   (color_t'(s_axis_tdata)),
        .palette (palette_reg),
        .sum_sq  (sum_sq)
    );

    for (genvar k = 0; k < NUM_COLORS; k++)
    begin : g_lane
        npc_isqrt u_isqrt (
            .clk      (clk),
            .en       (adv),
            .radicand (sum_sq[k]),
            .root     (lane_dist[k])
        );
    end

    npc_select #(.NUM_COLORS(NUM_COLORS)) u_select (
        .clk       (clk),
        .en        (adv),
        .lane_dist (lane_dist),
        .pixel     (pix_reg[PIX_DLY-1]),
        .palette   (palette_reg),
        .out_color (out_color),
        .out_index (m_axis_tuser)
    );

    assign m_axis_tvalid = valid_reg[LATENCY-1];
    assign m_axis_tdata  = out_color;

endmodule

`default_nettype wire

// ===== rtl/npc_dist.sv =====
// ----------------------------------------------------------------------------
// npc_dist : squared colour distance, one lane per palette entry
// Three stages: absolute channel differences, squares, sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_dist #(
    parameter int NUM_COLORS = npc_pkg::NUM_COLORS_DEF
) (
    input  wire                                          clk,
    input  wire                                          en,
    input  npc_pkg::color_t                              pixel,
    input  npc_pkg::palette_t                            palette,
    output logic [NUM_COLORS-1:0][npc_pkg::SUM_W-1:0]    sum_sq
);
    import npc_pkg::*;

    logic [NUM_COLORS-1:0][2:0][CH_W-1:0] diff_reg;
    logic [NUM_COLORS-1:0][2:0][CH_W-1:0] diff_next;
    logic [NUM_COLORS-1:0][2:0][SQ_W-1:0] sq_reg;
    logic [NUM_COLORS-1:0][SUM_W-1:0]     sum_reg;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Channel differences per lane
    always_comb
    begin
        for (int k = 0; k < NUM_COLORS; k++)
        begin
            diff_next[k][0] = abs_diff(pixel.blue,  palette[k].blue);
            diff_next[k][1] = abs_diff(pixel.green, palette[k].green);
            diff_next[k][2] = abs_diff(pixel.red,   palette[k].red);
        end
    end

    // Difference, square and sum registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            for (int k = 0; k < NUM_COLORS; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sq_reg[k][c] <= SQ_W'(diff_reg[k][c]) * SQ_W'(diff_reg[k][c]);
                end
                sum_reg[k] <= SUM_W'(sq_reg[k][0]) + SUM_W'(sq_reg[k][1])
                            + SUM_W'(sq_reg[k][2]);
            end
        end
    end

    assign sum_sq = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/npc_isqrt.sv =====
// ----------------------------------------------------------------------------
// npc_isqrt : pipelined floor square root of one lane's sum of squares
// Restoring digit-by-digit method, a few result bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_isqrt (
    input  wire                              clk,
    input  wire                              en,
    input  wire  [npc_pkg::SUM_W-1:0]        radicand,
    output logic [npc_pkg::ROOT_W-1:0]       root
);
    import npc_pkg::*;

    sqrt_st_t st_reg  [SQRT_STAGES];
    sqrt_st_t st_next [SQRT_STAGES];
    sqrt_st_t st_in   [SQRT_STAGES];

    assign st_in[0] = '{rad: radicand, rem: '0, root: '0};

    for (genvar s = 1; s < SQRT_STAGES; s++)
    begin : g_link
        assign st_in[s] = st_reg[s-1];
    end

    // A few dependent trial subtractions per stage
    always_comb
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            st_next[s] = st_in[s];
            for (int j = 0; j < SQRT_STEPS; j++)
            begin
                st_next[s] = sqrt_step(st_next[s]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < SQRT_STAGES; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign root = st_reg[SQRT_STAGES-1].root;

endmodule

`default_nettype wire

// ===== rtl/npc_select.sv =====
// ----------------------------------------------------------------------------
// npc_select : nearest entry search and output colour choice
// Stage one finds the winner (later index wins a tie), stage two drives
// either the palette colour or the untouched pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_select #(
    parameter int NUM_COLORS = npc_pkg::NUM_COLORS_DEF
) (
    input  wire                                          clk,
    input  wire                                          en,
    input  wire  [NUM_COLORS-1:0][npc_pkg::ROOT_W-1:0]   lane_dist,
    input  npc_pkg::color_t                              pixel,
    input  npc_pkg::palette_t                            palette,
    output npc_pkg::color_t                              out_color,
    output logic [npc_pkg::IDX_W-1:0]                    out_index
);
    import npc_pkg::*;

    logic [IDX_W-1:0]  win_next;
    logic [ROOT_W-1:0] best;
    logic [IDX_W-1:0]  win_reg;
    color_t            pix_reg;
    logic [IDX_W-1:0]  idx_reg;
    color_t            color_reg;

    // Running minimum over the lanes, ties go to the higher index
    always_comb
    begin
        best     = DIST_START;
        win_next = '0;
        for (int k = 0; k < NUM_COLORS; k++)
        begin
            if (best >= lane_dist[k])
            begin
                best     = lane_dist[k];
                win_next = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            win_reg <= win_next;
            pix_reg <= pixel;
            idx_reg <= win_reg;
            // background passes the pixel through
            color_reg <= (win_reg != '0) ? palette[win_reg] : pix_reg;
        end
    end

    assign out_color = color_reg;
    assign out_index = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/npc_checker.sv =====
// ----------------------------------------------------------------------------
// npc_checker : port-level checks on the palette colour classifier
// Output hold under stall, stall coupling, class index range and cfg ready.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_checker #(
    parameter int NUM_COLORS = npc_pkg::NUM_COLORS_DEF
) (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [npc_pkg::PIX_W-1:0]       m_axis_tdata,
    input wire [npc_pkg::IDX_W-1:0]       m_axis_tuser,
    input wire                            cfg_valid,
    input wire                            cfg_ready
);
    import npc_pkg::*;

    // A stalled output transfer keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled output transfer keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // Input back-pressure comes only from a full, stalled output
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready not tied to output stall");

    // Winner is always an active palette entry
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tuser} < (IDX_W+1)'(NUM_COLORS))
        else $error("class index beyond active palette");

    // Palette writes are never held off
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind nearest_palette_color_classifier npc_checker #(.NUM_COLORS(NUM_COLORS)) u_npc_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : nearest palette colour classifier
// Drives BGR pixels through the stream input and programs the palette
// between phases. Each pixel is classified by a local predictor, and every
// output transfer is checked field by field against the oldest pending
// prediction. Covers the reset palette, exact and background matches, ties
// in the floored distance, writes to indexes past the palette, random
// palettes with random pixels, and a long output hold-off.
// ----------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    localparam int NUM_ENTRIES      = NUM_COLORS_DEF;
    localparam int REG_PALETTE_BASE = 0;      // palette_color_0 .. _7
    localparam int REG_INDEX_LIMIT  = 1 << CFG_IDX_W;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PHASE_PIXELS     = 90;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_RUNS} rx_mode_e;
    typedef enum int {PAL_RANDOM, PAL_ZERO, PAL_WHITE, PAL_CORNERS, PAL_CLUSTER}
        palette_style_e;

    typedef struct packed {
        color_t           pixel;
        logic [IDX_W-1:0] class_index;
    } classified_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;
    logic [IDX_W-1:0]     m_axis_tuser;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [PIX_W-1:0]     cfg_data      = '0;

    // Local copy of the palette and the predictions still in flight
    palette_t    palette_shadow = '{default: '0};
    classified_t expected_results[$];
    int          mismatches = 0;

    // Pacing controls, set by the tests
    bit          sender_gaps = 1'b0;
    int          burst_left  = 0;
    rx_mode_e    rx_mode     = RX_ALWAYS;
    int          holdoff_len = 0;
    int          holdoff_seq = 0;

    nearest_palette_color_classifier #(
        .NUM_COLORS(NUM_ENTRIES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // blue, green, red
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // blue, green, red
        .m_axis_tuser  (m_axis_tuser),   // class_index
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Nearest entry by floored Euclidean distance, later index wins ties
    function automatic classified_t classify(color_t px);
        classified_t      res;
        color_t           entry;
        int               best;
        int               distance;
        int               sum_sq;
        int               db;
        int               dg;
        int               dr;
        int               trial;
        logic [IDX_W-1:0] winner;
        best   = int'(DIST_START);
        winner = '0;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            entry  = palette_shadow[k];
            db     = int'(px.blue) - int'(entry.blue);
            dg     = int'(px.green) - int'(entry.green);
            dr     = int'(px.red) - int'(entry.red);
            sum_sq = db * db + dg * dg + dr * dr;
            // integer square root, one result bit at a time
            distance = 0;
            for (int b = 8; b >= 0; b--) begin
                trial = distance | (1 << b);
                if (trial * trial <= sum_sq)
                    distance = trial;
            end
            if (best >= distance) begin
                best   = distance;
                winner = IDX_W'(k);
            end
        end
        res.pixel       = (winner != '0) ? palette_shadow[winner] : px;
        res.class_index = winner;
        return res;
    endfunction

    // Each channel moved by up to +/- span, clamped to the channel range
    function automatic color_t jitter(color_t base, int span);
        logic [PIX_W-1:0] v;
        int               x;
        v = base;
        for (int ch = 0; ch < 3; ch++) begin
            x = int'(v[ch*CH_W +: CH_W]) + int'($urandom_range(0, 2 * span)) - span;
            if (x < 0)
                x = 0;
            else if (x > 255)
                x = 255;
            v[ch*CH_W +: CH_W] = x[CH_W-1:0];
        end
        return color_t'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Compare each output transfer with the oldest prediction
    always @(posedge clk) begin : check_results
        classified_t want;
        color_t      got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = color_t'(m_axis_tdata);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer, class_index", m_axis_tuser, 0);
            end
            else begin
                want = expected_results.pop_front();
                if (got.blue != want.pixel.blue)
                    report_mismatch("out_blue", got.blue, want.pixel.blue);
                if (got.green != want.pixel.green)
                    report_mismatch("out_green", got.green, want.pixel.green);
                if (got.red != want.pixel.red)
                    report_mismatch("out_red", got.red, want.pixel.red);
                if (m_axis_tuser != want.class_index)
                    report_mismatch("class_index", m_axis_tuser, want.class_index);
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run
    always @(posedge clk) begin : watchdog
        int stall_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: stall pattern and requested hold-offs
    // ------------------------------------------------------------------------

    always @(negedge clk) begin : output_pacing
        int hold_left;
        int holdoff_seen;
        int run_left;
        bit run_level;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else if (holdoff_seq != holdoff_seen) begin
            holdoff_seen  = holdoff_seq;
            hold_left     = holdoff_len;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else begin
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if (run_left > 0) begin
                        run_left--;
                    end
                    else begin
                        run_level = ~run_level;
                        run_left  = $urandom_range(0, run_level ? 10 : 6);
                    end
                    m_axis_tready <= run_level;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input side and configuration
    // ------------------------------------------------------------------------

    // Bursts of random length separated by random gaps
    task automatic pace_sender();
        int gap;
        if (!sender_gaps)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // One pixel transfer; valid stays high for a following pixel
    task automatic send_pixel(color_t px);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results = {expected_results, classify(px)};
        pace_sender();
    endtask

    task automatic write_register(int idx, color_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < PALETTE_SLOTS)
            palette_shadow[idx] = value;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_palette(palette_t colours);
        for (int k = 0; k < PALETTE_SLOTS; k++)
            write_register(REG_PALETTE_BASE + k, colours[k]);
        end_writes();
    endtask

    // Stop offering, wait for every prediction, then let the pipeline settle
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Palette all zero after reset: every entry ties, the last one wins
    task automatic test_reset_palette();
        sender_gaps = 1'b0;
        rx_mode     = RX_ALWAYS;
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h123456);
        wait_drained();
    endtask

    // Exact hits on every entry, plus background pass-through
    task automatic test_exact_matches();
        palette_t colours;
        colours = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                    24'h0000FF, 24'h808080, 24'hFF00FF, 24'h00FFFF};
        program_palette(colours);
        rx_mode = RX_RANDOM;
        for (int k = 0; k < PALETTE_SLOTS; k++)
            send_pixel(colours[k]);
        send_pixel(24'h100810);   // near black: background, passes unchanged
        send_pixel(24'hF0F0F0);   // near white
        wait_drained();
    endtask

    // Equal floored distances: the highest tied index wins
    task automatic test_distance_ties();
        palette_t colours;
        // pixel 64_64_64: entries 1 and 2 at exactly 10, entry 3 at sqrt(101)
        colours = '{24'hFFFFFF, 24'h5A6464, 24'h64646E, 24'h646E65,
                    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
        program_palette(colours);
        rx_mode = RX_ALWAYS;
        send_pixel(24'h646464);
        send_pixel(24'hFFFFFF);   // background tied with entries 4 to 7
        send_pixel(24'hF0F0F0);
        wait_drained();
    endtask

    // Writes past the palette must not alias onto any entry
    task automatic test_ignored_registers();
        color_t probe;
        for (int idx = PALETTE_SLOTS; idx < REG_INDEX_LIMIT; idx++)
            write_register(idx, color_t'(24'h3C1E5A + idx * 24'h010305));
        end_writes();
        for (int idx = PALETTE_SLOTS; idx < REG_INDEX_LIMIT; idx += 2) begin
            probe = color_t'(24'h3C1E5A + idx * 24'h010305);
            send_pixel(probe);
        end
        wait_drained();
    endtask

    // New palette of the given style, then random pixels
    task automatic test_random_phase(palette_style_e style, bit gaps, rx_mode_e rx);
        palette_t colours;
        color_t   centre;
        color_t   px;
        int       pick;
        centre = color_t'($urandom_range(0, 24'hFFFFFF));
        for (int k = 0; k < PALETTE_SLOTS; k++) begin
            case (style)
                PAL_ZERO:    colours[k] = 24'h000000;
                PAL_WHITE:   colours[k] = 24'hFFFFFF;
                PAL_CORNERS: colours[k] = {{CH_W{k[2]}}, {CH_W{k[1]}}, {CH_W{k[0]}}};
                PAL_CLUSTER: colours[k] = jitter(centre, 6);
                default:     colours[k] = color_t'($urandom_range(0, 24'hFFFFFF));
            endcase
        end
        program_palette(colours);
        sender_gaps = gaps;
        rx_mode     = rx;
        for (int n = 0; n < PHASE_PIXELS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                px = jitter(palette_shadow[$urandom_range(0, PALETTE_SLOTS - 1)], 8);
            else if (pick < 8)
                px = color_t'($urandom_range(0, 24'hFFFFFF));
            else if (pick == 8)
                px = palette_shadow[$urandom_range(0, PALETTE_SLOTS - 1)];
            else
                px = {{CH_W{1'($urandom_range(0, 1))}}, {CH_W{1'($urandom_range(0, 1))}},
                      {CH_W{1'($urandom_range(0, 1))}}};
            send_pixel(px);
        end
        wait_drained();
    endtask

    // Output held off for a long stretch while pixels keep coming
    task automatic test_output_holdoff();
        sender_gaps = 1'b0;
        rx_mode     = RX_ALWAYS;
        holdoff_len = 300;
        holdoff_seq++;
        for (int n = 0; n < 40; n++)
            send_pixel(color_t'($urandom_range(0, 24'hFFFFFF)));
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_palette();
        test_exact_matches();
        test_distance_ties();
        test_ignored_registers();
        test_random_phase(PAL_RANDOM,  1'b1, RX_RANDOM);
        test_random_phase(PAL_ZERO,    1'b0, RX_ALWAYS);
        test_random_phase(PAL_WHITE,   1'b1, RX_RUNS);
        test_random_phase(PAL_CORNERS, 1'b1, RX_RANDOM);
        test_random_phase(PAL_CLUSTER, 1'b0, RX_RUNS);
        test_output_holdoff();
        test_random_phase(PAL_RANDOM,  1'b1, RX_RUNS);
        test_random_phase(PAL_CLUSTER, 1'b1, RX_ALWAYS);

        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), 0);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
